@@ hw/rtl/ipv4_dotted_quad_scanner_top_defines.svh @@
// Assertion macros shared by the checker of the dotted-quad scanner.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IPV4_DOTTED_QUAD_SCANNER_TOP_DEFINES_SVH
`define IPV4_DOTTED_QUAD_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

@@ hw/rtl/ipdq_pkg.sv @@
// Shared types, codes and character constants of the dotted-quad scanner.
// Depends on nothing; used by the controller, the datapath, the top and the checker.
package ipdq_pkg;

    localparam int TEXT_DEPTH = 17;
    localparam int LEN_W      = 5;

    localparam logic [2:0] OCT_IDLE = 3'd4;
    localparam logic [2:0] OCT_LAST = 3'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_ADDR  = 2'd2;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [11:0] OCTET_MAX = 12'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_ADDR,
        ST_CHAR
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_text;
        logic load_addr;
        logic load_char;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_text;
        logic plan_addr;
        logic plan_char;
        logic pend_addr;
        logic pend_char;
        logic text_last;
        logic out_free;
    } t_dp_status;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

endpackage

@@ hw/rtl/ipv4_dotted_quad_scanner_top.sv @@
// Top level of the IPv4 dotted-quad scanner: sequencer plus datapath.
// Depends on ipdq_pkg, ipdq_ctrl and ipdq_dp.
//
// The scanner takes one word per handshake (a byte, or an end-of-stream flush) and
// returns each word's results in order, the final one flagged by o_last. A word that
// yields no result (a digit, a dot or an opening bracket of an address being
// matched) is taken without holding off input. The results of a word leave one per
// cycle through the single output register when the receiver does not stall; the
// longest word is a closing bracket that releases seventeen text bytes and the
// address. Input is held off while the results of a word are being sent.
// Writing i_cfg_we discards any held address text and restarts matching in the new mode.
module ipv4_dotted_quad_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_address,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    ipdq_pkg::t_dp_cmd    ctl;
    ipdq_pkg::t_dp_status status;

    ipdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    ipdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_in_byte   (i_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_address   (o_address),
        .o_last      (o_last)
    );

endmodule

@@ hw/rtl/ipdq_ctrl.sv @@
// Sequencer of the dotted-quad scanner: accepts words and steps out their results.
// Depends on ipdq_pkg; drives the datapath through t_dp_cmd and reads t_dp_status.
module ipdq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ipdq_pkg::t_dp_status i_status,
    output ipdq_pkg::t_dp_cmd    o_ctl
);

    ipdq_pkg::t_state r_state;
    ipdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipdq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.plan_text) begin
                        n_state = ipdq_pkg::ST_TEXT;
                    end else if (i_status.plan_addr) begin
                        n_state = ipdq_pkg::ST_ADDR;
                    end else if (i_status.plan_char) begin
                        n_state = ipdq_pkg::ST_CHAR;
                    end
                end
            end
            ipdq_pkg::ST_TEXT: begin
                if (i_status.out_free && i_status.text_last) begin
                    if (i_status.pend_addr) begin
                        n_state = ipdq_pkg::ST_ADDR;
                    end else if (i_status.pend_char) begin
                        n_state = ipdq_pkg::ST_CHAR;
                    end else begin
                        n_state = ipdq_pkg::ST_IDLE;
                    end
                end
            end
            ipdq_pkg::ST_ADDR: begin
                if (i_status.out_free) begin
                    n_state = i_status.pend_char ? ipdq_pkg::ST_CHAR : ipdq_pkg::ST_IDLE;
                end
            end
            ipdq_pkg::ST_CHAR: begin
                if (i_status.out_free) begin
                    n_state = ipdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ipdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != ipdq_pkg::ST_IDLE);
        o_ctl.accept    = (r_state == ipdq_pkg::ST_IDLE) && i_in_valid;
        o_ctl.load_text = (r_state == ipdq_pkg::ST_TEXT) && i_status.out_free;
        o_ctl.load_addr = (r_state == ipdq_pkg::ST_ADDR) && i_status.out_free;
        o_ctl.load_char = (r_state == ipdq_pkg::ST_CHAR) && i_status.out_free;
    end

endmodule

@@ hw/rtl/ipdq_dp.sv @@
// Datapath of the dotted-quad scanner: match state, text store, result plan and output word.
// Depends on ipdq_pkg; commanded by ipdq_ctrl.
module ipdq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  ipdq_pkg::t_dp_cmd    i_ctl,
    output ipdq_pkg::t_dp_status o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_out_byte,
    output logic [31:0]          o_address,
    output logic                 o_last
);

    localparam int LW = ipdq_pkg::LEN_W;

    // Match state
    logic          r_bm;
    logic [2:0]    r_oi;
    logic [1:0]    r_dc;
    logic [7:0]    r_oct [4];
    logic [LW-1:0] r_len;
    logic [7:0]    r_text [ipdq_pkg::TEXT_DEPTH];

    // Plan of the word being answered
    logic [LW-1:0] r_fcnt;
    logic [LW-1:0] r_rd;
    logic [1:0]    r_tkind;
    logic          r_do_addr;
    logic          r_do_char;
    logic [31:0]   r_addr;
    logic [7:0]    r_char;

    // Output word
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_byte;
    logic [31:0]   r_out_addr;
    logic          r_out_last;

    logic [2:0]    n_oi;
    logic [1:0]    n_dc;
    logic [7:0]    n_oct [4];
    logic [LW-1:0] n_len;
    logic          push;
    logic [LW-1:0] p_fcnt;
    logic [1:0]    p_kind;
    logic          p_addr;
    logic          p_char;

    logic [1:0]    oi2;
    logic [7:0]    cur;
    logic [11:0]   val;
    logic          active;
    logic          dig;
    logic          aln;
    logic          room;
    logic          out_free;

    always_comb begin
        oi2    = r_oi[1:0];
        cur    = r_oct[oi2];
        val    = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {8'h00, i_in_byte[3:0]};
        active = (r_oi < ipdq_pkg::OCT_IDLE);
        dig    = ipdq_pkg::is_digit(i_in_byte);
        aln    = ipdq_pkg::is_alnum(i_in_byte);
        room   = (r_len < LW'(ipdq_pkg::TEXT_DEPTH));

        n_oi   = r_oi;
        n_dc   = r_dc;
        n_oct  = r_oct;
        n_len  = r_len;
        push   = 1'b0;
        p_fcnt = '0;
        p_kind = ipdq_pkg::KIND_PLAIN;
        p_addr = 1'b0;
        p_char = 1'b0;

        if (i_cmd == ipdq_pkg::CMD_EOS) begin
            if (!r_bm && (r_oi == ipdq_pkg::OCT_LAST) && (r_dc != 2'd0)) begin
                p_addr = 1'b1;
                p_kind = ipdq_pkg::KIND_TEXT;
            end
            p_fcnt = r_len;
            n_len  = '0;
            n_dc   = 2'd0;
            if (r_bm) begin
                n_oi = ipdq_pkg::OCT_IDLE;
            end else begin
                n_oi     = 3'd0;
                n_oct[0] = 8'h00;
            end
        end else if (!active && r_bm && (i_in_byte == ipdq_pkg::CH_LBRACK)) begin
            push     = 1'b1;
            n_len    = room ? r_len + 1'b1 : r_len;
            n_oi     = 3'd0;
            n_oct[0] = 8'h00;
            n_dc     = 2'd0;
        end else if (!active && !r_bm && !aln) begin
            p_char   = 1'b1;
            n_oi     = 3'd0;
            n_oct[0] = 8'h00;
            n_dc     = 2'd0;
        end else if (active && (r_dc != 2'd3) && dig && (val <= ipdq_pkg::OCTET_MAX)) begin
            n_oct[oi2] = val[7:0];
            push       = 1'b1;
            n_len      = room ? r_len + 1'b1 : r_len;
            n_dc       = r_dc + 2'd1;
        end else if (active && (r_oi != ipdq_pkg::OCT_LAST) && (r_dc != 2'd0) &&
                     (i_in_byte == ipdq_pkg::CH_DOT)) begin
            n_oi              = r_oi + 3'd1;
            n_oct[oi2 + 2'd1] = 8'h00;
            push              = 1'b1;
            n_len             = room ? r_len + 1'b1 : r_len;
            n_dc              = 2'd0;
        end else if ((r_oi == ipdq_pkg::OCT_LAST) && (r_dc != 2'd0) && r_bm &&
                     (i_in_byte == ipdq_pkg::CH_RBRACK)) begin
            // The closing bracket is held first, so it leaves as address text.
            push   = 1'b1;
            p_fcnt = room ? r_len + 1'b1 : r_len;
            p_kind = ipdq_pkg::KIND_TEXT;
            p_addr = 1'b1;
            n_len  = '0;
            n_oi   = ipdq_pkg::OCT_IDLE;
            n_dc   = 2'd0;
        end else if ((r_oi == ipdq_pkg::OCT_LAST) && (r_dc != 2'd0) && !r_bm && !aln) begin
            p_fcnt   = r_len;
            p_kind   = ipdq_pkg::KIND_TEXT;
            p_addr   = 1'b1;
            p_char   = 1'b1;
            n_len    = '0;
            n_oi     = 3'd0;
            n_oct[0] = 8'h00;
            n_dc     = 2'd0;
        end else begin
            p_fcnt = r_len;
            p_char = 1'b1;
            n_len  = '0;
            n_dc   = 2'd0;
            if (!r_bm && !aln) begin
                n_oi     = 3'd0;
                n_oct[0] = 8'h00;
            end else begin
                n_oi = ipdq_pkg::OCT_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bm  <= 1'b0;
            r_oi  <= 3'd0;
            r_dc  <= 2'd0;
            r_oct <= '{default: 8'h00};
            r_len <= '0;
        end else if (i_cfg_we) begin
            r_bm     <= i_cfg_wdata;
            r_len    <= '0;
            r_dc     <= 2'd0;
            r_oi     <= i_cfg_wdata ? ipdq_pkg::OCT_IDLE : 3'd0;
            r_oct[0] <= i_cfg_wdata ? r_oct[0] : 8'h00;
        end else if (i_ctl.accept) begin
            r_oi  <= n_oi;
            r_dc  <= n_dc;
            r_oct <= n_oct;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && push && room) begin
            r_text[r_len] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_addr <= 1'b0;
            r_do_char <= 1'b0;
            r_fcnt    <= '0;
            r_rd      <= '0;
        end else if (i_ctl.accept) begin
            r_do_addr <= p_addr;
            r_do_char <= p_char;
            r_fcnt    <= p_fcnt;
            r_rd      <= '0;
        end else if (i_ctl.load_text) begin
            r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_tkind <= p_kind;
            r_addr  <= {r_oct[0], r_oct[1], r_oct[2], r_oct[3]};
            r_char  <= i_in_byte;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_text || i_ctl.load_addr || i_ctl.load_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_text) begin
            r_out_kind <= r_tkind;
            r_out_byte <= r_text[r_rd];
            r_out_addr <= '0;
            r_out_last <= o_status.text_last && !r_do_addr && !r_do_char;
        end else if (i_ctl.load_addr) begin
            r_out_kind <= ipdq_pkg::KIND_ADDR;
            r_out_byte <= 8'h00;
            r_out_addr <= r_addr;
            r_out_last <= !r_do_char;
        end else if (i_ctl.load_char) begin
            r_out_kind <= ipdq_pkg::KIND_PLAIN;
            r_out_byte <= r_char;
            r_out_addr <= '0;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_status.plan_text = (p_fcnt != '0);
        o_status.plan_addr = p_addr;
        o_status.plan_char = p_char;
        o_status.pend_addr = r_do_addr;
        o_status.pend_char = r_do_char;
        o_status.text_last = (r_rd == r_fcnt - 1'b1);
        o_status.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_address   = r_out_addr;
    assign o_last      = r_out_last;

endmodule

@@ hw/rtl/ipdq_checker.sv @@
// Port-level checker of the dotted-quad scanner, bound to the top level.
// Depends on ipdq_pkg and ipv4_dotted_quad_scanner_top_defines.svh.
`include "ipv4_dotted_quad_scanner_top_defines.svh"

module ipdq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [31:0] o_address,
    input logic        o_last
);

    logic [42:0] out_word;
    logic        stalled;
    logic        kind_addr;
    logic        kind_byte;

    assign out_word  = {o_kind, o_out_byte, o_address, o_last};
    assign stalled   = o_out_valid && i_out_stall;
    assign kind_addr = o_out_valid && (o_kind == ipdq_pkg::KIND_ADDR);
    assign kind_byte = o_out_valid &&
                       ((o_kind == ipdq_pkg::KIND_PLAIN) || (o_kind == ipdq_pkg::KIND_TEXT));

    // A stalled result word must hold still.
    `IPDQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(out_word))

    // While a word still has results to come, no new input word may be taken.
    `IPDQ_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_valid && !o_last, o_in_stall)

    `IPDQ_ASSERT_IMPL(a_addr_byte_zero, i_clk, i_rst_n, kind_addr, o_out_byte == 8'h00)

    `IPDQ_ASSERT_IMPL(a_byte_addr_zero, i_clk, i_rst_n, kind_byte, o_address == 32'h0)

endmodule

bind ipv4_dotted_quad_scanner_top ipdq_checker u_checker (.*);
